[rtl/mpsq_pkg.sv]
// Package: sizes, command codes, status codes and state type for the message pool.
package mpsq_pkg;
    localparam int POOL_SLOTS  = 32;
    localparam int QUEUE_COUNT = 32;
    localparam int SENDER_BITS = 8;

    localparam int SLOT_W  = $clog2(POOL_SLOTS);
    localparam int LINK_W  = $clog2(POOL_SLOTS + 1);
    localparam int QID_W   = $clog2(QUEUE_COUNT);
    localparam int LIST_W  = $clog2(QUEUE_COUNT + 2);
    localparam int LISTS   = QUEUE_COUNT + 1;
    localparam int LIDX_W  = $clog2(LISTS);

    localparam logic [LINK_W-1:0] NIL       = LINK_W'(POOL_SLOTS);
    localparam logic [LIST_W-1:0] FREE_LIST = LIST_W'(QUEUE_COUNT);
    localparam logic [LIST_W-1:0] NO_LIST   = LIST_W'(QUEUE_COUNT + 1);

    // slot record: next, prev, owner
    localparam int REC_W = 2 * LINK_W + LIST_W;
    // list record: head, tail
    localparam int LREC_W = 2 * LINK_W;

    typedef enum logic [2:0] {
        CMD_ALLOC  = 3'd0,
        CMD_FREE   = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_PUSH   = 3'd3,
        CMD_POP    = 3'd4,
        CMD_PEEK   = 3'd5,
        CMD_TEST   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOMATCH = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_INIT,       // reset sweep of slot and list memories
        S_IDLE,
        S_LHEAD,      // read list record of target list
        S_CHK,        // list record ready
        S_SREAD,      // slot record read issued
        S_UNLINK,     // slot record ready: unlink step 1
        S_UNP,        // read prev slot
        S_UNPW,       // write prev.next
        S_UNN,        // read next slot
        S_UNNW,       // write next.prev
        S_UNL,        // read owner list record
        S_UNLW,       // write owner list record
        S_INS,        // read target list record
        S_INSR,       // list record ready
        S_INSO,       // read old head/tail slot
        S_INSOW,      // write neighbor link
        S_INSW,       // write slot and list record
        S_WALK,       // pop walk: read slot
        S_WALKR,      // slot record + tag ready
        S_CLR,        // clear walk: read slot
        S_CLRR,
        S_FIN,        // read list record for empty flag
        S_FINR,
        S_OUT
    } state_t;
endpackage

[rtl/mpsq_ram.sv]
// Generic single-port RAM with registered read.
module mpsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/message_pool_with_sender_queues_top.sv]
// Top level: message pool with linked-list queues and free list.
// One command at a time; out_valid rises once the result of the accepted command is ready.
// Pop walks the queue from its head one slot at a time until the sender tag matches
// (any_sender matches every slot) or the list ends; clear walks and detaches every
// slot of the queue. A new command can be accepted once out_valid rises.
// After reset a sweep initializes the memories; no item is accepted until it ends.
module message_pool_with_sender_queues_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [4:0] queue_id,
    input  logic [4:0] slot_index,
    input  logic [7:0] sender_id,
    input  logic       any_sender,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [4:0] result_slot,
    output logic [7:0] result_sender,
    output logic       queue_empty
);
    localparam int LW = mpsq_pkg::LINK_W;
    localparam int OW = mpsq_pkg::LIST_W;
    localparam int SW = mpsq_pkg::SLOT_W;
    localparam int IW = mpsq_pkg::LIDX_W;
    localparam int TW = mpsq_pkg::SENDER_BITS;

    mpsq_pkg::state_t state_reg, state_next;

    // command registers
    mpsq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [IW-1:0]    q_reg, q_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [TW-1:0]    snd_reg, snd_next;
    logic             any_reg, any_next;
    // work registers
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    p_reg, p_next, n_reg, n_next;
    logic [OW-1:0]    own_reg, own_next;
    logic [IW-1:0]    ins_reg, ins_next;     // list to insert into
    logic [LW-1:0]    oth_reg, oth_next;     // old head/tail of insert list
    logic [LW-1:0]    lh_reg, lh_next, lt_reg, lt_next;
    logic [SW:0]      steps_reg, steps_next;
    logic [IW:0]      init_reg, init_next;
    // result being built
    logic [1:0]       st_reg, st_next;
    logic [SW-1:0]    rs_reg, rs_next;
    logic [TW-1:0]    rt_reg, rt_next;
    logic             qe_reg, qe_next;
    logic             ov_reg, ov_next;
    // result on the output, held while stalled
    logic [1:0]       ost_reg, ost_next;
    logic [SW-1:0]    ors_reg, ors_next;
    logic [TW-1:0]    ort_reg, ort_next;
    logic             oqe_reg, oqe_next;

    // memories
    logic                        s_we, l_we, t_we;
    logic [SW-1:0]               s_addr, t_addr;
    logic [IW-1:0]               l_addr;
    logic [mpsq_pkg::REC_W-1:0]  s_wd, s_rd;
    logic [mpsq_pkg::LREC_W-1:0] l_wd, l_rd;
    logic [TW-1:0]               t_wd, t_rd;

    logic [LW-1:0] rd_next_l, rd_prev_l, rd_head, rd_tail;
    logic [OW-1:0] rd_own;
    assign rd_next_l = s_rd[mpsq_pkg::REC_W-1 -: LW];
    assign rd_prev_l = s_rd[OW + LW - 1 -: LW];
    assign rd_own    = s_rd[OW-1:0];
    assign rd_head   = l_rd[2*LW-1 -: LW];
    assign rd_tail   = l_rd[LW-1:0];

    mpsq_ram #(.WIDTH(mpsq_pkg::REC_W), .DEPTH(mpsq_pkg::POOL_SLOTS)) u_slot (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
    mpsq_ram #(.WIDTH(mpsq_pkg::LREC_W), .DEPTH(mpsq_pkg::LISTS)) u_list (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
    mpsq_ram #(.WIDTH(TW), .DEPTH(mpsq_pkg::POOL_SLOTS)) u_tag (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));

    assign in_stall      = (state_reg != mpsq_pkg::S_IDLE);
    assign out_valid     = ov_reg;
    assign status        = ost_reg;
    assign result_slot   = 5'(ors_reg);
    assign result_sender = 8'(ort_reg);
    assign queue_empty   = oqe_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpsq_pkg::S_INIT;
            init_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;   q_reg <= q_next;   s_reg <= s_next;
        snd_reg <= snd_next;   any_reg <= any_next;
        cur_reg <= cur_next;   p_reg <= p_next;   n_reg <= n_next;
        own_reg <= own_next;   ins_reg <= ins_next; oth_reg <= oth_next;
        lh_reg <= lh_next;     lt_reg <= lt_next; steps_reg <= steps_next;
        st_reg <= st_next;     rs_reg <= rs_next; rt_reg <= rt_next;
        qe_reg <= qe_next;
        ost_reg <= ost_next;   ors_reg <= ors_next; ort_reg <= ort_next;
        oqe_reg <= oqe_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpsq_pkg::S_INIT:
                if (init_reg == (IW+1)'(mpsq_pkg::LISTS - 1)) state_next = mpsq_pkg::S_IDLE;
            mpsq_pkg::S_IDLE:
                if (in_valid) state_next = mpsq_pkg::S_LHEAD;
            mpsq_pkg::S_LHEAD: state_next = mpsq_pkg::S_CHK;
            mpsq_pkg::S_CHK:
                case (cmd_reg)
                    mpsq_pkg::CMD_ALLOC:
                        state_next = (rd_head == mpsq_pkg::NIL) ? mpsq_pkg::S_FIN
                                                                : mpsq_pkg::S_SREAD;
                    mpsq_pkg::CMD_FREE, mpsq_pkg::CMD_APPEND, mpsq_pkg::CMD_PUSH:
                        state_next = mpsq_pkg::S_SREAD;
                    mpsq_pkg::CMD_POP:
                        state_next = (rd_head == mpsq_pkg::NIL) ? mpsq_pkg::S_FIN
                                                                : mpsq_pkg::S_WALK;
                    mpsq_pkg::CMD_PEEK:
                        state_next = (rd_head == mpsq_pkg::NIL) ? mpsq_pkg::S_FIN
                                                                : mpsq_pkg::S_SREAD;
                    // clear with empty queue: nothing to walk
                    mpsq_pkg::CMD_CLEAR:
                        state_next = (rd_head == mpsq_pkg::NIL) ? mpsq_pkg::S_FIN
                                                                : mpsq_pkg::S_CLR;
                    default: state_next = mpsq_pkg::S_FIN;
                endcase
            mpsq_pkg::S_SREAD: state_next = mpsq_pkg::S_UNLINK;
            mpsq_pkg::S_UNLINK:
                if (cmd_reg == mpsq_pkg::CMD_PEEK) state_next = mpsq_pkg::S_FIN;
                else if (rd_own > mpsq_pkg::FREE_LIST)
                    state_next = (cmd_reg == mpsq_pkg::CMD_ALLOC || cmd_reg == mpsq_pkg::CMD_POP)
                                 ? mpsq_pkg::S_FIN : mpsq_pkg::S_INS;
                else state_next = mpsq_pkg::S_UNP;
            mpsq_pkg::S_UNP:  state_next = mpsq_pkg::S_UNPW;
            mpsq_pkg::S_UNPW: state_next = mpsq_pkg::S_UNN;
            mpsq_pkg::S_UNN:  state_next = mpsq_pkg::S_UNNW;
            mpsq_pkg::S_UNNW: state_next = mpsq_pkg::S_UNL;
            mpsq_pkg::S_UNL:  state_next = mpsq_pkg::S_UNLW;
            mpsq_pkg::S_UNLW:
                state_next = (cmd_reg == mpsq_pkg::CMD_ALLOC || cmd_reg == mpsq_pkg::CMD_POP)
                             ? mpsq_pkg::S_FIN : mpsq_pkg::S_INS;
            mpsq_pkg::S_INS:  state_next = mpsq_pkg::S_INSR;
            mpsq_pkg::S_INSR: state_next = mpsq_pkg::S_INSO;
            mpsq_pkg::S_INSO: state_next = mpsq_pkg::S_INSOW;
            mpsq_pkg::S_INSOW: state_next = mpsq_pkg::S_INSW;
            mpsq_pkg::S_INSW: state_next = mpsq_pkg::S_FIN;
            mpsq_pkg::S_WALK: state_next = mpsq_pkg::S_WALKR;
            mpsq_pkg::S_WALKR:
                if (any_reg || t_rd == snd_reg) state_next = mpsq_pkg::S_UNLINK;
                else if (rd_next_l == mpsq_pkg::NIL
                         || steps_reg == (SW+1)'(mpsq_pkg::POOL_SLOTS - 1))
                    state_next = mpsq_pkg::S_FIN;
                else state_next = mpsq_pkg::S_WALK;
            mpsq_pkg::S_CLR: state_next = mpsq_pkg::S_CLRR;
            mpsq_pkg::S_CLRR:
                state_next = (rd_next_l == mpsq_pkg::NIL
                              || steps_reg == (SW+1)'(mpsq_pkg::POOL_SLOTS - 1))
                             ? mpsq_pkg::S_FIN : mpsq_pkg::S_CLR;
            mpsq_pkg::S_FIN:  state_next = mpsq_pkg::S_FINR;
            mpsq_pkg::S_FINR: state_next = mpsq_pkg::S_OUT;
            mpsq_pkg::S_OUT:
                if (!ov_reg || !out_stall) state_next = mpsq_pkg::S_IDLE;
            default: state_next = mpsq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        cmd_next = cmd_reg; q_next = q_reg; s_next = s_reg; snd_next = snd_reg;
        any_next = any_reg; cur_next = cur_reg; p_next = p_reg; n_next = n_reg;
        own_next = own_reg; ins_next = ins_reg; oth_next = oth_reg;
        lh_next = lh_reg; lt_next = lt_reg; steps_next = steps_reg;
        st_next = st_reg; rs_next = rs_reg; rt_next = rt_reg; qe_next = qe_reg;
        ost_next = ost_reg; ors_next = ors_reg; ort_next = ort_reg; oqe_next = oqe_reg;
        init_next = init_reg;
        ov_next = ov_reg && out_stall;
        s_we = 1'b0; l_we = 1'b0; t_we = 1'b0;
        s_addr = cur_reg[SW-1:0]; l_addr = q_reg; t_addr = cur_reg[SW-1:0];
        s_wd = '0; l_wd = '0; t_wd = snd_reg;
        case (state_reg)
            mpsq_pkg::S_INIT:
            begin
                // slot i: next i-1 (NIL for 0), prev i+1 (NIL for top), owner free
                s_addr = init_reg[SW-1:0];
                s_we = (init_reg < (IW+1)'(mpsq_pkg::POOL_SLOTS));
                s_wd = {(init_reg == '0) ? mpsq_pkg::NIL : LW'(init_reg - 1'b1),
                        LW'(init_reg + 1'b1), mpsq_pkg::FREE_LIST};
                l_addr = init_reg[IW-1:0];
                l_we = 1'b1;
                l_wd = (init_reg == (IW+1)'(mpsq_pkg::QUEUE_COUNT))
                       ? {LW'(mpsq_pkg::POOL_SLOTS - 1), LW'(0)}
                       : {mpsq_pkg::NIL, mpsq_pkg::NIL};
                init_next = init_reg + 1'b1;
            end
            mpsq_pkg::S_IDLE:
            begin
                cmd_next = mpsq_pkg::cmd_t'(cmd);
                q_next = IW'(queue_id % mpsq_pkg::QUEUE_COUNT);
                s_next = SW'(slot_index % mpsq_pkg::POOL_SLOTS);
                snd_next = TW'(sender_id);
                any_next = any_sender;
                st_next = mpsq_pkg::ST_OK; rs_next = '0; rt_next = '0;
                steps_next = '0;
            end
            mpsq_pkg::S_LHEAD:
            begin
                l_addr = (cmd_reg == mpsq_pkg::CMD_ALLOC) ? IW'(mpsq_pkg::QUEUE_COUNT) : q_reg;
            end
            mpsq_pkg::S_CHK:
            begin
                cur_next = (cmd_reg == mpsq_pkg::CMD_FREE || cmd_reg == mpsq_pkg::CMD_APPEND
                            || cmd_reg == mpsq_pkg::CMD_PUSH) ? LW'(s_reg) : rd_head;
                ins_next = (cmd_reg == mpsq_pkg::CMD_FREE) ? IW'(mpsq_pkg::QUEUE_COUNT) : q_reg;
                case (cmd_reg)
                    mpsq_pkg::CMD_ALLOC, mpsq_pkg::CMD_POP, mpsq_pkg::CMD_PEEK:
                        if (rd_head == mpsq_pkg::NIL) st_next = mpsq_pkg::ST_EMPTY;
                    mpsq_pkg::CMD_TEST:
                        st_next = (rd_head == mpsq_pkg::NIL) ? mpsq_pkg::ST_EMPTY
                                                             : mpsq_pkg::ST_OK;
                    default: ;
                endcase
                if (cmd_reg == mpsq_pkg::CMD_POP && rd_head != mpsq_pkg::NIL)
                    st_next = mpsq_pkg::ST_NOMATCH;
            end
            mpsq_pkg::S_SREAD: ;
            mpsq_pkg::S_UNLINK:
            begin
                p_next = rd_prev_l; n_next = rd_next_l; own_next = rd_own;
                if (cmd_reg == mpsq_pkg::CMD_PEEK)
                begin
                    rs_next = cur_reg[SW-1:0]; rt_next = t_rd;
                end
                else if (cmd_reg == mpsq_pkg::CMD_ALLOC || cmd_reg == mpsq_pkg::CMD_POP)
                begin
                    rs_next = cur_reg[SW-1:0];
                    if (cmd_reg == mpsq_pkg::CMD_POP) rt_next = t_rd;
                    st_next = mpsq_pkg::ST_OK;
                end
                else
                begin
                    rs_next = cur_reg[SW-1:0];
                    if (cmd_reg != mpsq_pkg::CMD_FREE) rt_next = snd_reg;
                end
                // detach the slot itself
                if (cmd_reg != mpsq_pkg::CMD_PEEK && rd_own <= mpsq_pkg::FREE_LIST)
                begin
                    s_we = 1'b1;
                    s_wd = {mpsq_pkg::NIL, mpsq_pkg::NIL, mpsq_pkg::NO_LIST};
                end
            end
            mpsq_pkg::S_UNP: s_addr = p_reg[SW-1:0];
            mpsq_pkg::S_UNPW:
            begin
                s_addr = p_reg[SW-1:0];
                s_we = (p_reg != mpsq_pkg::NIL);
                s_wd = {n_reg, rd_prev_l, rd_own};
            end
            mpsq_pkg::S_UNN: s_addr = n_reg[SW-1:0];
            mpsq_pkg::S_UNNW:
            begin
                s_addr = n_reg[SW-1:0];
                s_we = (n_reg != mpsq_pkg::NIL);
                s_wd = {rd_next_l, p_reg, rd_own};
            end
            mpsq_pkg::S_UNL: l_addr = own_reg[IW-1:0];
            mpsq_pkg::S_UNLW:
            begin
                l_addr = own_reg[IW-1:0];
                l_we = 1'b1;
                l_wd = {(p_reg == mpsq_pkg::NIL) ? n_reg : rd_head,
                        (n_reg == mpsq_pkg::NIL) ? p_reg : rd_tail};
            end
            mpsq_pkg::S_INS: l_addr = ins_reg;
            mpsq_pkg::S_INSR:
            begin
                l_addr = ins_reg;
                lh_next = rd_head; lt_next = rd_tail;
                oth_next = (cmd_reg == mpsq_pkg::CMD_PUSH) ? rd_head : rd_tail;
            end
            mpsq_pkg::S_INSO: s_addr = oth_reg[SW-1:0];
            mpsq_pkg::S_INSOW:
            begin
                s_addr = oth_reg[SW-1:0];
                s_we = (oth_reg != mpsq_pkg::NIL);
                s_wd = (cmd_reg == mpsq_pkg::CMD_PUSH)
                       ? {rd_next_l, LW'(s_reg), rd_own}
                       : {LW'(s_reg), rd_prev_l, rd_own};
            end
            mpsq_pkg::S_INSW:
            begin
                s_addr = s_reg; s_we = 1'b1;
                l_addr = ins_reg; l_we = 1'b1;
                t_addr = s_reg; t_we = (cmd_reg != mpsq_pkg::CMD_FREE);
                if (cmd_reg == mpsq_pkg::CMD_PUSH)
                begin
                    s_wd = {oth_reg, mpsq_pkg::NIL, OW'(ins_reg)};
                    l_wd = {LW'(s_reg), (oth_reg == mpsq_pkg::NIL) ? LW'(s_reg) : lt_reg};
                end
                else
                begin
                    s_wd = {mpsq_pkg::NIL, oth_reg, OW'(ins_reg)};
                    l_wd = {(oth_reg == mpsq_pkg::NIL) ? LW'(s_reg) : lh_reg, LW'(s_reg)};
                end
            end
            mpsq_pkg::S_WALK, mpsq_pkg::S_CLR: ;
            mpsq_pkg::S_WALKR:
            begin
                steps_next = steps_reg + 1'b1;
                if (!(any_reg || t_rd == snd_reg)) cur_next = rd_next_l;
            end
            mpsq_pkg::S_CLRR:
            begin
                s_we = 1'b1;
                s_wd = {mpsq_pkg::NIL, mpsq_pkg::NIL, mpsq_pkg::NO_LIST};
                cur_next = rd_next_l;
                steps_next = steps_reg + 1'b1;
                l_we = (rd_next_l == mpsq_pkg::NIL
                        || steps_reg == (SW+1)'(mpsq_pkg::POOL_SLOTS - 1));
                l_wd = {mpsq_pkg::NIL, mpsq_pkg::NIL};
            end
            mpsq_pkg::S_FIN: ;
            mpsq_pkg::S_FINR: qe_next = (rd_head == mpsq_pkg::NIL);
            mpsq_pkg::S_OUT:
                // move the finished result to the output once it is free
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ost_next = st_reg; ors_next = rs_reg;
                    ort_next = rt_reg; oqe_next = qe_reg;
                end
            default: ;
        endcase
    end
endmodule
